[hdl/rci_pkg.sv]
// shared types and constants for the ray / centred cube intersection unit
// no dependencies; imported by ray_cube_intersection_unit and its bench
package rci_pkg;

   localparam int FRACTION_BITS_DEF = 16;
   localparam int COORD_W = 32;
   localparam int DIST_W = 31;
   localparam int FACE_W = 3;
   localparam int NUM_AXES = 3;
   localparam int NUM_FACES = 6;
   localparam logic [DIST_W-1:0] HALF_EDGE_RESET = 31'd32768;
   localparam logic [DIST_W-1:0] T_MAX = '1;

   // one ray in object space
   typedef struct packed {
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic signed [COORD_W-1:0] origin_z;
      logic signed [COORD_W-1:0] dir_x;
      logic signed [COORD_W-1:0] dir_y;
      logic signed [COORD_W-1:0] dir_z;
      logic [DIST_W-1:0]         max_distance;
   } req_type;

   // one intersection result
   typedef struct packed {
      logic              hit;
      logic [DIST_W-1:0] hit_distance;
      logic [FACE_W-1:0] face_index;
   } rsp_type;

   // axis of a face: faces come in pairs +a, -a
   function automatic logic [1:0] face_axis(input logic [FACE_W-1:0] f);
      logic [1:0] a;
      unique case (f)
         3'd0, 3'd1: a = 2'd0;
         3'd2, 3'd3: a = 2'd1;
         default:    a = 2'd2;
      endcase
      return a;
   endfunction

   // cyclic successor of an axis
   function automatic logic [1:0] next_axis(input logic [1:0] a);
      logic [1:0] n;
      unique case (a)
         2'd0:    n = 2'd1;
         2'd1:    n = 2'd2;
         default: n = 2'd0;
      endcase
      return n;
   endfunction

endpackage

[hdl/ray_cube_intersection_unit.sv]
// ray / centred cube intersection, fully pipelined
// depends on rci_pkg
//
// Usage: rays enter on the req_ channel (valid/ready) as one req_type
// transaction; one rsp_type transaction leaves on rsp_ for every ray, in order.
// The cube half-edge is written on csr_ (always ready); the user must write
// it only while the unit is idle, the block itself does not enforce this.
// Reset sets it to 0.5 and empties the pipeline. The stages are one input
// register, one stage forming the six plane numerators, 31 divider stages
// (one quotient bit each, six dividers side by side), one multiply stage,
// one bounds-check stage, a stage picking the nearer face of each axis pair
// and the output register picking the nearest face overall. Throughput is
// one ray per cycle while the skid register is empty. When the receiver
// stalls, the output register holds its transaction and one more transaction
// drops into a skid register; after that req_ready falls and the whole pipeline
// freezes, losing nothing. req_ready rises again in the cycle after the output is taken.
module ray_cube_intersection_unit #(
   parameter int FRACTION_BITS = rci_pkg::FRACTION_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rci_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rci_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [rci_pkg::DIST_W-1:0] csr_wdata
);
   import rci_pkg::*;

   localparam int NW = COORD_W + FRACTION_BITS;
   localparam int RW = (NW > 2 * DIST_W + 1) ? NW : 2 * DIST_W + 1;
   localparam int QB = DIST_W;
   localparam int PW = 2 * COORD_W;

   typedef struct packed {
      logic [NUM_AXES-1:0][COORD_W-1:0] p;
      logic [NUM_AXES-1:0][COORD_W-1:0] d;
      logic [DIST_W-1:0]                h;
      logic [DIST_W-1:0]                maxd;
   } ctx_type;

   typedef struct packed {
      logic              ok;
      logic              sat;
      logic [RW-1:0]     rem;
      logic [COORD_W-1:0] dm;
      logic [QB-1:0]     q;
   } lane_type;

   // one restoring division step
   function automatic lane_type div_step(input lane_type x, input int unsigned bp);
      lane_type y;
      logic [RW-1:0] trial;
      y = x;
      trial = RW'(x.dm) << bp;
      if (x.rem >= trial) begin
         y.rem = x.rem - trial;
         y.q[bp] = 1'b1;
      end
      return y;
   endfunction

   logic adv;

   // half-edge register
   logic [DIST_W-1:0] half_edge_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         half_edge_ff <= HALF_EDGE_RESET;
      end else if (csr_valid) begin
         half_edge_ff <= csr_wdata;
      end
   end

   // pipeline registers
   logic     s0_valid_ff;
   ctx_type  s0_ctx_ff, s0_ctx_in;
   logic     dv_ff [0:QB];
   ctx_type  dctx_ff [0:QB];
   lane_type dl_ff [0:QB][0:NUM_FACES-1];
   lane_type dl0_in [0:NUM_FACES-1];
   logic     mv_ff;
   ctx_type  mctx_ff;
   logic     mok_ff [0:NUM_FACES-1];
   logic [QB-1:0] mt_ff [0:NUM_FACES-1];
   logic signed [PW-1:0] mprod_ff [0:NUM_FACES-1][0:1];
   logic signed [PW-1:0] mprod_in [0:NUM_FACES-1][0:1];
   logic [QB-1:0] t_in [0:NUM_FACES-1];
   logic     cv_ff;
   logic [DIST_W-1:0] cmaxd_ff;
   logic     cok_ff [0:NUM_FACES-1], cok_in [0:NUM_FACES-1];
   logic [QB-1:0] ct_ff [0:NUM_FACES-1];
   logic     rv_ff;
   logic [DIST_W-1:0] rmaxd_ff;
   logic     rok_ff [0:NUM_AXES-1], rok_in [0:NUM_AXES-1];
   logic [QB-1:0] rt_ff [0:NUM_AXES-1], rt_in [0:NUM_AXES-1];
   logic [FACE_W-1:0] rf_ff [0:NUM_AXES-1], rf_in [0:NUM_AXES-1];
   rsp_type  fin;
   logic     out_valid_ff, skid_valid_ff;
   rsp_type  out_ff, skid_ff;

   assign adv = !skid_valid_ff;
   assign req_ready = adv;

   // input capture
   always_comb begin
      s0_ctx_in.p[0] = req_payload.origin_x;
      s0_ctx_in.p[1] = req_payload.origin_y;
      s0_ctx_in.p[2] = req_payload.origin_z;
      s0_ctx_in.d[0] = req_payload.dir_x;
      s0_ctx_in.d[1] = req_payload.dir_y;
      s0_ctx_in.d[2] = req_payload.dir_z;
      s0_ctx_in.h    = half_edge_ff;
      s0_ctx_in.maxd = req_payload.max_distance;
   end

   // plane numerators, sign rejection and saturation check
   always_comb begin
      logic signed [COORD_W+1:0] plane, pa, num, nabs;
      logic signed [COORD_W:0] da, dabs;
      logic [1:0] ax;
      for (int l = 0; l < NUM_FACES; l++) begin
         ax = face_axis(FACE_W'(l));
         plane = l[0] ? -$signed({3'b000, s0_ctx_ff.h}) : $signed({3'b000, s0_ctx_ff.h});
         pa = (COORD_W+2)'($signed(s0_ctx_ff.p[ax]));
         num = plane - pa;
         da = (COORD_W+1)'($signed(s0_ctx_ff.d[ax]));
         nabs = num[COORD_W+1] ? -num : num;
         dabs = da[COORD_W] ? -da : da;
         dl0_in[l].ok  = (da != '0) && !((num != '0) && (num[COORD_W+1] != da[COORD_W]));
         dl0_in[l].dm  = dabs[COORD_W-1:0];
         dl0_in[l].rem = RW'(nabs[COORD_W-1:0]) << FRACTION_BITS;
         dl0_in[l].sat = dl0_in[l].rem >= (RW'(dabs[COORD_W-1:0]) << QB);
         dl0_in[l].q   = '0;
      end
   end

   // saturated quotient and hit-coordinate products
   always_comb begin
      logic [1:0] ax, a1;
      for (int l = 0; l < NUM_FACES; l++) begin
         t_in[l] = dl_ff[QB][l].sat ? T_MAX : dl_ff[QB][l].q;
         ax = face_axis(FACE_W'(l));
         a1 = next_axis(ax);
         mprod_in[l][0] = $signed(dctx_ff[QB].d[a1]) * $signed({1'b0, t_in[l]});
         mprod_in[l][1] = $signed(dctx_ff[QB].d[next_axis(a1)]) * $signed({1'b0, t_in[l]});
      end
   end

   // bounds check of the hit point on the other two axes
   always_comb begin
      logic [1:0] ax, a1;
      logic signed [PW:0] c0, c1, hp, hn;
      for (int l = 0; l < NUM_FACES; l++) begin
         ax = face_axis(FACE_W'(l));
         a1 = next_axis(ax);
         hp = (PW+1)'($signed({1'b0, mctx_ff.h}));
         hn = -hp;
         c0 = (PW+1)'($signed(mctx_ff.p[a1])) + (PW+1)'(mprod_ff[l][0] >>> FRACTION_BITS);
         c1 = (PW+1)'($signed(mctx_ff.p[next_axis(a1)]))
            + (PW+1)'(mprod_ff[l][1] >>> FRACTION_BITS);
         cok_in[l] = mok_ff[l] && (c0 >= hn) && (c0 <= hp) && (c1 >= hn) && (c1 <= hp);
      end
   end

   // nearer face of each axis pair, lower index on ties
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         if (cok_ff[2*a] && (!cok_ff[2*a+1] || ct_ff[2*a] <= ct_ff[2*a+1])) begin
            rok_in[a] = 1'b1;
            rt_in[a]  = ct_ff[2*a];
            rf_in[a]  = FACE_W'(2*a);
         end else begin
            rok_in[a] = cok_ff[2*a+1];
            rt_in[a]  = ct_ff[2*a+1];
            rf_in[a]  = FACE_W'(2*a+1);
         end
      end
   end

   // nearest face overall and distance limit
   always_comb begin
      logic found;
      logic [QB-1:0] bt;
      logic [FACE_W-1:0] bf;
      found = rok_ff[0];
      bt = rt_ff[0];
      bf = rf_ff[0];
      for (int a = 1; a < NUM_AXES; a++) begin
         if (rok_ff[a] && (!found || rt_ff[a] < bt)) begin
            found = 1'b1;
            bt = rt_ff[a];
            bf = rf_ff[a];
         end
      end
      if (found && bt <= rmaxd_ff) begin
         fin.hit = 1'b1;
         fin.hit_distance = bt;
         fin.face_index = bf;
      end else begin
         fin = '0;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         for (int k = 0; k <= QB; k++) begin
            dv_ff[k] <= 1'b0;
         end
         mv_ff <= 1'b0;
         cv_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req_valid;
         dv_ff[0] <= s0_valid_ff;
         for (int k = 0; k < QB; k++) begin
            dv_ff[k+1] <= dv_ff[k];
         end
         mv_ff <= dv_ff[QB];
         cv_ff <= mv_ff;
         rv_ff <= cv_ff;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ctx_ff <= s0_ctx_in;
         dctx_ff[0] <= s0_ctx_ff;
         for (int l = 0; l < NUM_FACES; l++) begin
            dl_ff[0][l] <= dl0_in[l];
         end
         for (int k = 0; k < QB; k++) begin
            dctx_ff[k+1] <= dctx_ff[k];
            for (int l = 0; l < NUM_FACES; l++) begin
               dl_ff[k+1][l] <= div_step(dl_ff[k][l], QB - 1 - k);
            end
         end
         mctx_ff <= dctx_ff[QB];
         for (int l = 0; l < NUM_FACES; l++) begin
            mok_ff[l] <= dl_ff[QB][l].ok;
            mt_ff[l] <= t_in[l];
            mprod_ff[l][0] <= mprod_in[l][0];
            mprod_ff[l][1] <= mprod_in[l][1];
            cok_ff[l] <= cok_in[l];
            ct_ff[l] <= mt_ff[l];
         end
         cmaxd_ff <= mctx_ff.maxd;
         rmaxd_ff <= cmaxd_ff;
         for (int a = 0; a < NUM_AXES; a++) begin
            rok_ff[a] <= rok_in[a];
            rt_ff[a] <= rt_in[a];
            rf_ff[a] <= rf_in[a];
         end
      end
   end

   // output register and skid register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            if (rsp_ready) begin
               out_ff <= skid_ff;
               skid_valid_ff <= 1'b0;
            end
         end else if (rv_ff) begin
            if (!out_valid_ff || rsp_ready) begin
               out_ff <= fin;
               out_valid_ff <= 1'b1;
            end else begin
               skid_ff <= fin;
               skid_valid_ff <= 1'b1;
            end
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_payload = out_ff;

   // checks
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while output empty");
   a_face_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.hit |-> rsp_payload.face_index <= FACE_W'(NUM_FACES - 1))
      else $error("face index out of range");
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.hit |-> rsp_payload.hit_distance == '0
         && rsp_payload.face_index == '0)
      else $error("miss result carries nonzero fields");
   a_skid_stalls: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !rsp_ready |=> skid_valid_ff && $stable(skid_ff))
      else $error("skid transaction lost under stall");

endmodule

[bench/ray_cube_intersection_unit_test.sv]
// self-checking bench for ray_cube_intersection_unit: rays in, hit results out
// depends on rci_pkg and ray_cube_intersection_unit
module ray_cube_intersection_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import rci_pkg::*;

   localparam int FB = FRACTION_BITS_DEF;
   localparam int PIPE_LATENCY = 36;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [DIST_W-1:0] csr_wdata = '0;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int error_count = 0;
   longint cube_half = 32768;
   rsp_type expected_hits[$];

   ray_cube_intersection_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // floor of v / 2^FB
   function automatic longint floor_fix(input longint v);
      return v >>> FB;
   endfunction

   // plane parameter, returns 0 if rejected
   function automatic bit plane_param(input longint plane, input longint p,
                                      input longint d, output longint t);
      longint num, nm, dm, q;
      t = 0;
      num = plane - p;
      if (d == 0) return 0;
      if (num != 0 && ((num < 0) != (d < 0))) return 0;
      nm = num < 0 ? -num : num;
      dm = d < 0 ? -d : d;
      q = (nm <<< FB) / dm;
      if (q > longint'(T_MAX)) q = longint'(T_MAX);
      t = q;
      return 1;
   endfunction

   // nearest face hit of one ray against the current cube
   function automatic rsp_type predict_hit(input req_type r);
      longint p[3], d[3], t, best_t, h, c;
      int best_face, a1, a2;
      bit found, ok;
      rsp_type res;
      h = cube_half;
      p[0] = longint'(r.origin_x); p[1] = longint'(r.origin_y);
      p[2] = longint'(r.origin_z);
      d[0] = longint'(r.dir_x); d[1] = longint'(r.dir_y); d[2] = longint'(r.dir_z);
      found = 0; best_t = 0; best_face = 0;
      for (int ax = 0; ax < 3; ax++) begin
         a1 = (ax + 1) % 3;
         a2 = (ax + 2) % 3;
         for (int side = 0; side < 2; side++) begin
            if (!plane_param(side == 0 ? h : -h, p[ax], d[ax], t)) continue;
            c = p[a1] + floor_fix(d[a1] * t);
            ok = c >= -h && c <= h;
            c = p[a2] + floor_fix(d[a2] * t);
            ok = ok && c >= -h && c <= h;
            if (ok && (!found || t < best_t)) begin
               found = 1;
               best_t = t;
               best_face = ax * 2 + side;
            end
         end
      end
      res = '0;
      if (found && best_t <= longint'(r.max_distance)) begin
         res.hit = 1'b1;
         res.hit_distance = best_t[DIST_W-1:0];
         res.face_index = best_face[FACE_W-1:0];
      end
      return res;
   endfunction

   // send one ray transaction; valid stays high into the next one unless it idles
   task automatic send_ray(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      expected_hits.push_back(predict_hit(r));
      req_payload <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // receiver stalls
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_hits.size() == 0) begin
            $error("unexpected result transaction");
            error_count++;
         end else begin
            rsp_type e;
            e = expected_hits.pop_front();
            if (rsp_payload.hit !== e.hit) begin
               $error("hit: expected %0d actual %0d", e.hit, rsp_payload.hit);
               error_count++;
            end
            if (rsp_payload.hit_distance !== e.hit_distance) begin
               $error("hit_distance: expected %0d actual %0d",
                      e.hit_distance, rsp_payload.hit_distance);
               error_count++;
            end
            if (rsp_payload.face_index !== e.face_index) begin
               $error("face_index: expected %0d actual %0d",
                      e.face_index, rsp_payload.face_index);
               error_count++;
            end
         end
      end
   end

   // stop sending and wait for the pipeline to drain
   task automatic drain;
      req_valid <= 1'b0;
      while (expected_hits.size() != 0) @(negedge clock);
      repeat (PIPE_LATENCY + 4) @(negedge clock);
   endtask

   // write the half-edge register while idle
   task automatic write_half_edge(input logic [DIST_W-1:0] value);
      drain();
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      cube_half = longint'(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic req_type make_ray(input longint ox, oy, oz, dx, dy, dz, md);
      req_type r;
      r.origin_x = ox[COORD_W-1:0]; r.origin_y = oy[COORD_W-1:0];
      r.origin_z = oz[COORD_W-1:0];
      r.dir_x = dx[COORD_W-1:0]; r.dir_y = dy[COORD_W-1:0]; r.dir_z = dz[COORD_W-1:0];
      r.max_distance = md[DIST_W-1:0];
      return r;
   endfunction

   // random word with bias toward small and extreme values
   function automatic logic [31:0] rand_coord(input longint scale);
      case ($urandom_range(5))
         0: return $urandom;
         1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
         2: return 0;
         default: return 32'(longint'($urandom_range(2 * scale)) - scale);
      endcase
   endfunction

   // aimed ray: random origin, direction mostly toward near the cube centre
   function automatic req_type rand_ray(input longint h);
      req_type r;
      longint s;
      s = (h > 32'h0100_0000) ? 32'h0400_0000 : 4 * h + 4;
      r.origin_x = rand_coord(s); r.origin_y = rand_coord(s);
      r.origin_z = rand_coord(s);
      r.dir_x = rand_coord(s); r.dir_y = rand_coord(s); r.dir_z = rand_coord(s);
      if ($urandom_range(3) != 0) begin
         r.dir_x = -r.origin_x + 32'($urandom_range(h) );
         r.dir_y = -r.origin_y;
         r.dir_z = -r.origin_z - 32'($urandom_range(h));
      end
      r.max_distance = $urandom_range(1) ? 31'($urandom) : DIST_W'($urandom_range(1 << 18));
      return r;
   endfunction

   // directed: axis hits, ties, zero directions, extremes
   task automatic test_directed;
      longint one;
      one = 1 << FB;
      send_ray(make_ray(-2 * one, 0, 0, one, 0, 0, T_MAX));
      send_ray(make_ray(2 * one, 0, 0, -one, 0, 0, T_MAX));
      send_ray(make_ray(0, -2 * one, 0, 0, one, 0, T_MAX));
      send_ray(make_ray(0, 2 * one, 0, 0, -one, 0, T_MAX));
      send_ray(make_ray(0, 0, -2 * one, 0, 0, one, T_MAX));
      send_ray(make_ray(0, 0, 2 * one, 0, 0, -one, T_MAX));
      send_ray(make_ray(-one, -one, 0, one, one, 0, T_MAX));
      send_ray(make_ray(-one, -one, -one, one, one, one, T_MAX));
      send_ray(make_ray(0, 0, 0, 0, 0, 0, T_MAX));
      send_ray(make_ray(0, 0, 0, one, 0, 0, T_MAX));
      send_ray(make_ray(-2 * one, 0, 0, one, 0, 0, one));
      send_ray(make_ray(-2 * one, 0, 0, one, 0, 0, 0));
      send_ray(make_ray(-2 * one, 0, 0, -one, 0, 0, T_MAX));
      send_ray(make_ray(32'sh8000_0000, 0, 0, 1, 0, 0, T_MAX));
      send_ray(make_ray(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                        32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, T_MAX));
      send_ray(make_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                        32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, T_MAX));
      send_ray(make_ray(32'sh8000_0000, 0, 0, 32'sh7fff_ffff, 1, -1, T_MAX));
      send_ray(make_ray(-one, 3 * one, 0, one, 0, 0, T_MAX));
      send_ray(make_ray(0, 0, 0, 32'shffff_ffff, 32'shffff_ffff, 32'shffff_ffff, T_MAX));
      send_ray(make_ray(one / 2, 0, 0, one, 0, 0, T_MAX));
   endtask

   // random rays under one idling mode
   task automatic test_random(input int count, input int idle, input int stall);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      repeat (count) send_ray(rand_ray(cube_half));
      drain();
      send_idle_pct = 0;
      recv_stall_pct = 0;
   endtask

   // sequence of tests
   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(110, 0, 0);
      write_half_edge(31'd1);
      test_directed();
      test_random(50, 86, 0);
      write_half_edge(T_MAX);
      test_directed();
      test_random(50, 0, 86);
      write_half_edge(31'd65536);
      test_random(60, 10, 10);
      write_half_edge(31'd200000);
      test_random(60, 0, 0);
      write_half_edge(31'd32768);
      test_random(60, 86, 86);
      drain();
      if (error_count == 0)
         $display("ray_cube_intersection_unit_test: PASS");
      else
         $display("ray_cube_intersection_unit_test: FAIL");
      $finish;
   end

   // timeout
   initial begin
      #50ms;
      $display("ray_cube_intersection_unit_test: FAIL");
      $finish;
   end
endmodule

[filelist.f]
hdl/rci_pkg.sv
hdl/ray_cube_intersection_unit.sv
bench/ray_cube_intersection_unit_test.sv
